// ===== sv/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// Mercator screen projection package
// Shared constants, types and helper functions for the projection pipeline.
// ----------------------------------------------------------------------------
package msp_pkg;

	// Pipeline sizing.
	localparam int CORDIC_STAGES = 24;
	localparam int LOG_STEPS     = 28;
	localparam int LOG_LAT       = LOG_STEPS + 2;
	localparam int X_POST        = 3;
	localparam int Y_POST        = LOG_LAT + 6;
	localparam int X_DLY         = Y_POST - X_POST;
	localparam int MODE_DLY      = LOG_LAT + 4;
	localparam int PIPE_DEPTH    = 1 + CORDIC_STAGES + Y_POST;

	// Angle and scaling constants.
	localparam logic signed [33:0] PI_Q28         = 34'sd843314857;
	localparam logic signed [33:0] HALF_PI_Q28    = 34'sd421657428;
	localparam logic signed [33:0] QUARTER_PI_Q28 = 34'sd210828714;
	localparam logic signed [33:0] CORDIC_GAIN    = 34'sd652032874;
	localparam logic signed [31:0] LN2_Q30        = 32'sd744261118;
	localparam logic signed [39:0] OUT_MAX        = 40'sd8388607;
	localparam logic signed [39:0] OUT_MIN        = -40'sd8388608;

	// Configuration register indexes.
	localparam logic [2:0] REG_CENTER_LAT = 3'd0;
	localparam logic [2:0] REG_CENTER_LON = 3'd1;
	localparam logic [2:0] REG_SCALE_X    = 3'd2;
	localparam logic [2:0] REG_SCALE_Y    = 3'd3;
	localparam logic [2:0] REG_OFFSET_X   = 3'd4;
	localparam logic [2:0] REG_OFFSET_Y   = 3'd5;

	// Vertical result class.
	typedef enum logic [1:0] {
		YM_NORMAL,
		YM_NEG_INF,
		YM_POS_INF
	} ymode_t;

	// Side data that rides alongside the rotation pipelines.
	typedef struct packed {
		logic                neg;
		logic signed [31:0]  dlon;
		ymode_t              mode;
	} side_t;

	// One clipped coordinate with its flag.
	typedef struct packed {
		logic signed [23:0] val;
		logic               sat;
	} coord_t;

	// Arctangent of 2^-i in Q2.30.
	function automatic logic signed [33:0] atan_q30(input int i);
		logic signed [33:0] r;
		case (i)
			0:  r = 34'sh3243F6A8;
			1:  r = 34'sh1DAC6705;
			2:  r = 34'sh0FADBAFC;
			3:  r = 34'sh07F56EA6;
			4:  r = 34'sh03FEAB76;
			5:  r = 34'sh01FFD55B;
			6:  r = 34'sh00FFFAAA;
			7:  r = 34'sh007FFF55;
			8:  r = 34'sh003FFFEA;
			9:  r = 34'sh001FFFFD;
			10: r = 34'sh000FFFFF;
			11: r = 34'sh0007FFFF;
			12: r = 34'sh0003FFFF;
			13: r = 34'sh0001FFFF;
			14: r = 34'sh0000FFFF;
			15: r = 34'sh00007FFF;
			16: r = 34'sh00003FFF;
			17: r = 34'sh00001FFF;
			18: r = 34'sh00000FFF;
			19: r = 34'sh000007FF;
			20: r = 34'sh000003FF;
			21: r = 34'sh000001FF;
			22: r = 34'sh000000FF;
			23: r = 34'sh0000007F;
			24: r = 34'sh0000003F;
			25: r = 34'sh0000001F;
			26: r = 34'sh0000000F;
			27: r = 34'sh00000008;
			28: r = 34'sh00000004;
			29: r = 34'sh00000002;
			30: r = 34'sh00000001;
			default: r = 34'sh0;
		endcase
		return r;
	endfunction

	// Clip a wide sum into the 24-bit signed output range.
	function automatic coord_t clip24(input logic signed [39:0] v);
		coord_t r;
		if (v > OUT_MAX) begin
			r.val = 24'sd8388607;
			r.sat = 1'b1;
		end else if (v < OUT_MIN) begin
			r.val = -24'sd8388608;
			r.sat = 1'b1;
		end else begin
			r.val = v[23:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== sv/msp_cordic.sv =====
// ----------------------------------------------------------------------------
// Rotation CORDIC
// Fully pipelined circular rotation, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module msp_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic signed [33:0] z_in,
	output logic signed [33:0] cos_out,
	output logic signed [33:0] sin_out
);
	import msp_pkg::*;

	logic signed [33:0] x_q [CORDIC_STAGES];
	logic signed [33:0] y_q [CORDIC_STAGES];
	logic signed [33:0] z_q [CORDIC_STAGES];

	// Each stage rotates by the arctangent of 2^-i towards zero residual angle.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		logic signed [33:0] xi, yi, zi, dx, dy;
		if (i == 0) begin : g_first
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign zi = z_in;
		end else begin : g_next
			assign xi = x_q[i-1];
			assign yi = y_q[i-1];
			assign zi = z_q[i-1];
		end
		assign dx = yi >>> i;
		assign dy = xi >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				if (zi >= 0) begin
					x_q[i] <= xi - dx;
					y_q[i] <= yi + dy;
					z_q[i] <= zi - atan_q30(i);
				end else begin
					x_q[i] <= xi + dx;
					y_q[i] <= yi - dy;
					z_q[i] <= zi + atan_q30(i);
				end
			end
		end
	end

	assign cos_out = x_q[CORDIC_STAGES-1];
	assign sin_out = y_q[CORDIC_STAGES-1];

	// The reset is not needed by payload stages; it is tied off here.
	logic unused_rst;
	assign unused_rst = arst_n;

endmodule

// ===== sv/msp_log2.sv =====
// ----------------------------------------------------------------------------
// Pipelined base-2 logarithm
// Normalises a positive Q2.30 value, then squares once per stage to produce
// one fraction bit per stage; result is Q.28.
// ----------------------------------------------------------------------------
module msp_log2 (
	input  logic               clk,
	input  logic               en,
	input  logic signed [33:0] v_in,
	output logic signed [34:0] log_out
);
	import msp_pkg::*;

	logic [32:0]        v_s1;
	logic [5:0]         p_s1;
	logic [30:0]        m_s2;
	logic signed [6:0]  e_s2;
	logic [5:0]         p_c;
	logic [32:0]        v_c;

	logic [30:0]        m_q [LOG_STEPS];
	logic [27:0]        f_q [LOG_STEPS];
	logic signed [6:0]  e_q [LOG_STEPS];

	// Leading-one position.
	assign v_c = v_in[32:0];
	always_comb begin
		p_c = '0;
		for (int b = 0; b < 33; b++) begin
			if (v_c[b]) begin
				p_c = 6'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= v_c;
			p_s1 <= p_c;
		end
	end

	// Mantissa alignment to [1, 2) in Q.30.
	always_ff @(posedge clk) begin
		if (en) begin
			if (p_s1 >= 6'd30) begin
				m_s2 <= 31'(v_s1 >> (p_s1 - 6'd30));
			end else begin
				m_s2 <= 31'(v_s1 << (6'd30 - p_s1));
			end
			e_s2 <= $signed({1'b0, p_s1}) - 7'sd30;
		end
	end

	// One squaring per stage yields the next fraction bit.
	for (genvar k = 0; k < LOG_STEPS; k++) begin : g_sq
		logic [30:0]       mi;
		logic [27:0]       fi;
		logic signed [6:0] ei;
		logic [61:0]       sq;
		logic [31:0]       t;
		if (k == 0) begin : g_first
			assign mi = m_s2;
			assign fi = '0;
			assign ei = e_s2;
		end else begin : g_next
			assign mi = m_q[k-1];
			assign fi = f_q[k-1];
			assign ei = e_q[k-1];
		end
		assign sq = 62'(mi) * 62'(mi);
		assign t  = sq[61:30];

		always_ff @(posedge clk) begin
			if (en) begin
				e_q[k] <= ei;
				if (t[31]) begin
					m_q[k] <= t[31:1];
					f_q[k] <= fi | (28'd1 << (27 - k));
				end else begin
					m_q[k] <= t[30:0];
					f_q[k] <= fi;
				end
			end
		end
	end

	assign log_out = $signed({e_q[LOG_STEPS-1], f_q[LOG_STEPS-1]});

endmodule

// ===== sv/mercator_screen_projection_core.sv =====
// ----------------------------------------------------------------------------
// Mercator screen projection core
// Projects vertex latitude/longitude to saturated Q16.8 screen coordinates.
// ----------------------------------------------------------------------------
// The core takes one vertex per clock cycle while in_stall is low and returns
// one result per vertex in order. The pipeline depth is set by the 24-stage
// rotation CORDIC, followed by the 30-stage logarithm unit and the scaling
// multipliers on the vertical path. A stall on the result side freezes the
// whole pipeline while a result is waiting; nothing is lost or repeated.
// Configuration writes are always accepted and must only be made while the
// pipeline is empty.
module mercator_screen_projection_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [30:0] latitude,
	input  logic signed [30:0] longitude,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] x_pixel,
	output logic signed [23:0] y_pixel,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import msp_pkg::*;

	logic signed [30:0] center_lat_q, center_lon_q;
	logic [31:0]        scale_x_q, scale_y_q;
	logic signed [23:0] offset_x_q, offset_y_q;

	logic               en;
	logic               vld_q [PIPE_DEPTH];

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_lat_q <= '0;
			center_lon_q <= '0;
			scale_x_q    <= 32'd65536;
			scale_y_q    <= 32'd65536;
			offset_x_q   <= '0;
			offset_y_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CENTER_LAT: center_lat_q <= cfg_data[30:0];
				REG_CENTER_LON: center_lon_q <= cfg_data[30:0];
				REG_SCALE_X:    scale_x_q    <= cfg_data;
				REG_SCALE_Y:    scale_y_q    <= cfg_data;
				REG_OFFSET_X:   offset_x_q   <= cfg_data[23:0];
				REG_OFFSET_Y:   offset_y_q   <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Global advance: the pipeline moves unless a waiting result is held.
	assign en       = !(vld_q[PIPE_DEPTH-1] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIPE_DEPTH; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < PIPE_DEPTH; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// Front stage: latitude folding, longitude offset and vertical angle.
	logic signed [33:0] lat_w, r_c, d_c, a_c;
	logic               neg_c;
	ymode_t             mode_c;
	logic signed [33:0] zx_s1, zy_s1;
	side_t              side_s1;

	assign lat_w = 34'(latitude);
	always_comb begin
		neg_c = 1'b1;
		if (lat_w > HALF_PI_Q28) begin
			r_c = lat_w - PI_Q28;
		end else if (lat_w < -HALF_PI_Q28) begin
			r_c = lat_w + PI_Q28;
		end else begin
			r_c   = lat_w;
			neg_c = 1'b0;
		end
		d_c = 34'(32'(latitude) - 32'(center_lat_q));
		a_c = (d_c >>> 1) + QUARTER_PI_Q28;
		if (a_c <= 0) begin
			mode_c = YM_NEG_INF;
		end else if (a_c >= HALF_PI_Q28) begin
			mode_c = YM_POS_INF;
		end else begin
			mode_c = YM_NORMAL;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zx_s1        <= r_c <<< 2;
			zy_s1        <= a_c <<< 2;
			side_s1.neg  <= neg_c;
			side_s1.dlon <= 32'(longitude) - 32'(center_lon_q);
			side_s1.mode <= mode_c;
		end
	end

	// Two rotation pipelines: one for cos(latitude), one for the tangent angle.
	logic signed [33:0] cx_c, sx_c, cy_c, sy_c;

	msp_cordic u_cordic_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.z_in    (zx_s1),
		.cos_out (cx_c),
		.sin_out (sx_c)
	);

	msp_cordic u_cordic_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.z_in    (zy_s1),
		.cos_out (cy_c),
		.sin_out (sy_c)
	);

	// Side data delayed to match the rotation pipelines.
	side_t side_q [CORDIC_STAGES];
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s1;
			for (int k = 1; k < CORDIC_STAGES; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	side_t side_c;
	assign side_c = side_q[CORDIC_STAGES-1];

	// Horizontal path: cosine times longitude offset, then scale and offset.
	logic signed [33:0] cxn_c;
	logic signed [63:0] px_s2, qx_s3;
	logic signed [29:0] mx_c;
	logic signed [39:0] sx_sum;
	coord_t             x_s4;

	assign cxn_c = side_c.neg ? -cx_c : cx_c;
	assign mx_c  = px_s2[63:34];
	assign sx_sum = 40'($signed(qx_s3[63:32])) + 40'(offset_x_q);

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= 64'(cxn_c) * 64'(side_c.dlon);
			qx_s3 <= 64'(mx_c) * 64'($signed({1'b0, scale_x_q})) + 64'sd2147483648;
			x_s4  <= clip24(sx_sum);
		end
	end

	// Horizontal results wait for the longer vertical path.
	coord_t xd_q [X_DLY];
	always_ff @(posedge clk) begin
		if (en) begin
			xd_q[0] <= x_s4;
			for (int k = 1; k < X_DLY; k++) begin
				xd_q[k] <= xd_q[k-1];
			end
		end
	end

	// Vertical path: classify the CORDIC result and pick logarithm operands.
	ymode_t             mode_y0;
	logic signed [33:0] s_y0, c_y0;

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_c.mode != YM_NORMAL) begin
				mode_y0 <= side_c.mode;
				s_y0    <= 34'sd1;
				c_y0    <= 34'sd1;
			end else if (sy_c <= 0) begin
				mode_y0 <= YM_NEG_INF;
				s_y0    <= 34'sd1;
				c_y0    <= 34'sd1;
			end else if (cy_c <= 0) begin
				mode_y0 <= YM_POS_INF;
				s_y0    <= 34'sd1;
				c_y0    <= 34'sd1;
			end else begin
				mode_y0 <= YM_NORMAL;
				s_y0    <= sy_c;
				c_y0    <= cy_c;
			end
		end
	end

	logic signed [34:0] ls_c, lc_c;

	msp_log2 u_log_sin (
		.clk     (clk),
		.en      (en),
		.v_in    (s_y0),
		.log_out (ls_c)
	);

	msp_log2 u_log_cos (
		.clk     (clk),
		.en      (en),
		.v_in    (c_y0),
		.log_out (lc_c)
	);

	// Class delayed to meet the final vertical stage.
	ymode_t md_q [MODE_DLY];
	always_ff @(posedge clk) begin
		if (en) begin
			md_q[0] <= mode_y0;
			for (int k = 1; k < MODE_DLY; k++) begin
				md_q[k] <= md_q[k-1];
			end
		end
	end

	// Log ratio, times ln 2 in two partial products, then scale and offset.
	// The upper partial product carries the sign of the log ratio.
	logic signed [35:0] lq_y1;
	logic signed [49:0] ph_y2;
	logic [46:0]        pl_y2;
	logic signed [33:0] ln_y3;
	logic signed [67:0] py_y4;
	logic signed [67:0] lsum_c;
	logic signed [39:0] sy_sum;
	coord_t             y_clip_c;
	coord_t             y_y5;

	assign lsum_c   = (68'(ph_y2) <<< 17) + 68'($signed({1'b0, pl_y2}));
	assign sy_sum   = 40'($signed(py_y4[67:32])) + 40'(offset_y_q);
	assign y_clip_c = clip24(sy_sum);

	always_ff @(posedge clk) begin
		if (en) begin
			lq_y1 <= 36'(ls_c) - 36'(lc_c);
			ph_y2 <= 50'($signed(lq_y1[35:17])) * 50'(LN2_Q30);
			pl_y2 <= 47'(lq_y1[16:0]) * 47'(LN2_Q30);
			ln_y3 <= lsum_c[67:34];
			py_y4 <= 68'(ln_y3) * 68'($signed({1'b0, scale_y_q})) + 68'sd2147483648;
			case (md_q[MODE_DLY-1])
				YM_NEG_INF: begin
					y_y5.val <= -24'sd8388608;
					y_y5.sat <= 1'b1;
				end
				YM_POS_INF: begin
					y_y5.val <= 24'sd8388607;
					y_y5.sat <= 1'b1;
				end
				default: y_y5 <= y_clip_c;
			endcase
		end
	end

	// Result port.
	assign out_valid = vld_q[PIPE_DEPTH-1];
	assign x_pixel   = xd_q[X_DLY-1].val;
	assign y_pixel   = y_y5.val;
	assign saturated = xd_q[X_DLY-1].sat | y_y5.sat;

	// Unused sine of the horizontal rotation.
	logic unused_sx;
	assign unused_sx = ^sx_c;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Mercator projection core testbench
// Streams vertices through the core under random source and sink idling,
// predicts each projected coordinate pair in fixed point and compares every
// result transfer field by field. Configuration is changed between phases
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
	import msp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint PI_L     = 843314857;
	localparam longint HPI_L    = 421657428;
	localparam longint QPI_L    = 210828714;
	localparam longint GAIN_L   = 652032874;
	localparam longint LN2_L    = 744261118;
	localparam longint MAXV     = 8388607;
	localparam longint MINV     = -8388608;
	localparam int     ANG_MAX  = 843314857;

	// Projected result of one vertex.
	typedef struct {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic               sat;
	} screen_pt_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [30:0] latitude;
	logic signed [30:0] longitude;
	logic               out_valid;
	logic               out_stall;
	logic signed [23:0] x_pixel;
	logic signed [23:0] y_pixel;
	logic               saturated;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;

	// Shadow copy of the configuration registers.
	longint ctr_lat, ctr_lon, scl_x, scl_y, off_x, off_y;

	screen_pt_t pending_pts[$];
	int         mismatches;
	int         src_idle_pct;
	int         snk_idle_pct;

	mercator_screen_projection_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.latitude  (latitude),
		.longitude (longitude),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.x_pixel   (x_pixel),
		.y_pixel   (y_pixel),
		.saturated (saturated),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock generation.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Floor shift right.
	function automatic longint fshr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint arctan_step(input int i);
		return longint'(atan_q30(i));
	endfunction

	// Rotation CORDIC: angle in Q2.30, cosine and sine out in Q2.30.
	task automatic rotate(input longint z, output longint cs, output longint sn);
		longint xr, yr, dx, dy;
		xr = GAIN_L;
		yr = 0;
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			dx = fshr(yr, i);
			dy = fshr(xr, i);
			if (z >= 0) begin
				xr -= dx; yr += dy; z -= arctan_step(i);
			end else begin
				xr += dx; yr -= dy; z += arctan_step(i);
			end
		end
		cs = xr;
		sn = yr;
	endtask

	// Base-2 logarithm of a positive Q2.30 value, result in Q.28.
	function automatic longint log2_fix(input longint v);
		int     p;
		longint m, frac;
		p = 62;
		frac = 0;
		while (p > 0 && v[p] == 1'b0)
			p--;
		if (p >= 30)
			m = v >>> (p - 30);
		else
			m = v <<< (30 - p);
		for (int k = 0; k < 28; k++) begin
			m = (m * m) >>> 30;
			if (m >= (longint'(1) << 31)) begin
				m = m >>> 1;
				frac |= longint'(1) << (27 - k);
			end
		end
		return longint'(p - 30) * (longint'(1) << 28) + frac;
	endfunction

	function automatic longint clamp_px(input longint v, inout logic f);
		if (v > MAXV) begin
			f = 1'b1;
			return MAXV;
		end
		if (v < MINV) begin
			f = 1'b1;
			return MINV;
		end
		return v;
	endfunction

	// Predicted screen position of one vertex under the current registers.
	task automatic project_vertex(input logic signed [30:0] la, input logic signed [30:0] lo,
			output screen_pt_t pt);
		longint lat, lon, r, c, s, m, xv, yv, a, lq, lnv;
		logic   neg, f;
		lat = la;
		lon = lo;
		f = 1'b0;
		neg = 1'b0;
		// Horizontal: cosine of latitude folded into the principal range.
		if (lat > HPI_L) begin
			r = lat - PI_L; neg = 1'b1;
		end else if (lat < -HPI_L) begin
			r = lat + PI_L; neg = 1'b1;
		end else begin
			r = lat;
		end
		rotate(r * 4, c, s);
		if (neg)
			c = -c;
		m = fshr(c * (lon - ctr_lon), 34);
		xv = fshr(m * scl_x + (longint'(1) << 31), 32) + off_x;
		xv = clamp_px(xv, f);
		// Vertical: log of the tangent of the half angle.
		a = fshr(lat - ctr_lat, 1) + QPI_L;
		if (a <= 0) begin
			yv = MINV; f = 1'b1;
		end else if (a >= HPI_L) begin
			yv = MAXV; f = 1'b1;
		end else begin
			rotate(a * 4, c, s);
			if (s <= 0) begin
				yv = MINV; f = 1'b1;
			end else if (c <= 0) begin
				yv = MAXV; f = 1'b1;
			end else begin
				lq = log2_fix(s) - log2_fix(c);
				lnv = fshr(lq * LN2_L, 34);
				yv = fshr(lnv * scl_y + (longint'(1) << 31), 32) + off_y;
				yv = clamp_px(yv, f);
			end
		end
		pt.x = xv[23:0];
		pt.y = yv[23:0];
		pt.sat = f;
	endtask

	// Writes one configuration register and updates the shadow copy.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_CENTER_LAT: ctr_lat = longint'(signed'(val[30:0]));
			REG_CENTER_LON: ctr_lon = longint'(signed'(val[30:0]));
			REG_SCALE_X:    scl_x = longint'({1'b0, val});
			REG_SCALE_Y:    scl_y = longint'({1'b0, val});
			REG_OFFSET_X:   off_x = longint'(signed'(val[23:0]));
			REG_OFFSET_Y:   off_y = longint'(signed'(val[23:0]));
			default: ;
		endcase
	endtask

	task automatic write_all(input longint cla, input longint clo, input longint sx,
			input longint sy, input longint ox, input longint oy);
		write_reg(REG_CENTER_LAT, 32'(cla));
		write_reg(REG_CENTER_LON, 32'(clo));
		write_reg(REG_SCALE_X, 32'(sx));
		write_reg(REG_SCALE_Y, 32'(sy));
		write_reg(REG_OFFSET_X, 32'(ox));
		write_reg(REG_OFFSET_Y, 32'(oy));
	endtask

	// Sends one vertex, with random idle cycles before it.
	task automatic send_vertex(input logic signed [30:0] la, input logic signed [30:0] lo);
		screen_pt_t pt;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		project_vertex(la, lo, pt);
		latitude <= la;
		longitude <= lo;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_pts = {pending_pts, pt};
	endtask

	// Lets the pipeline drain before the next configuration change.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pts.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
	endtask

	function automatic logic signed [30:0] rand_angle();
		return 31'($signed($urandom_range(2 * ANG_MAX)) - ANG_MAX);
	endfunction

	function automatic logic signed [30:0] rand_raw31();
		return 31'($urandom);
	endfunction

	// Extremes of the fields, the tangent limits and the cosine folding.
	task automatic test_directed();
		send_vertex(0, 0);
		send_vertex(31'sd843314857, 31'sd843314857);
		send_vertex(-31'sd843314857, -31'sd843314857);
		send_vertex(31'sd421657428, 31'sd100000);
		send_vertex(31'sd421657429, 31'sd100000);
		send_vertex(-31'sd421657428, -31'sd100000);
		send_vertex(-31'sd421657429, -31'sd100000);
		send_vertex(31'sd421657427, 31'sd1);
		send_vertex(-31'sd421657427, -31'sd1);
		send_vertex(-31'sd421657424, 31'sd0);
		send_vertex(31'h3FFFFFFF, 31'h3FFFFFFF);
		send_vertex(31'h40000000, 31'h40000000);
		send_vertex(31'h7FFFFFFF, 31'h55555555);
		send_vertex(31'h2AAAAAAA, 31'h7FFFFFFF);
		send_vertex(31'sd1000000, -31'sd1000000);
		send_vertex(-31'sd1000000, 31'sd1000000);
	endtask

	// Random vertices in and beyond the stated range.
	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				send_vertex(rand_raw31(), rand_raw31());
			else if ($urandom_range(4) == 0)
				send_vertex(31'($signed($urandom_range(600000000)) - 300000000),
					31'($signed($urandom_range(2000000)) - 1000000));
			else
				send_vertex(rand_angle(), rand_angle());
		end
	endtask

	// Random configuration, sometimes at the register extremes.
	task automatic test_config_phase(input int n);
		longint v[6];
		v[0] = $signed($urandom_range(2 * ANG_MAX)) - ANG_MAX;
		v[1] = $signed($urandom_range(2 * ANG_MAX)) - ANG_MAX;
		v[2] = $urandom_range(5) == 0 ? longint'($urandom) : $urandom_range(32'h0400_0000);
		v[3] = $urandom_range(5) == 0 ? longint'($urandom) : $urandom_range(32'h0400_0000);
		v[4] = $signed($urandom_range(24'hFFFFFF)) - 8388608;
		v[5] = $signed($urandom_range(24'hFFFFFF)) - 8388608;
		write_all(v[0], v[1], v[2], v[3], v[4], v[5]);
		test_random(n);
		drain();
	endtask

	// Sink side: random stalls and the result comparison.
	always @(posedge clk) begin
		screen_pt_t exp_pt;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_pts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer x=%0d y=%0d sat=%0b",
							x_pixel, y_pixel, saturated);
				end else begin
					exp_pt = pending_pts.pop_front();
					if (x_pixel !== exp_pt.x || y_pixel !== exp_pt.y
							|| saturated !== exp_pt.sat) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp x=%0d y=%0d sat=%0b got x=%0d y=%0d sat=%0b",
								exp_pt.x, exp_pt.y, exp_pt.sat, x_pixel, y_pixel, saturated);
					end
				end
			end
			out_stall <= ($urandom_range(99) < snk_idle_pct);
		end
	end

	// Run time limit.
	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		latitude = '0;
		longitude = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		src_idle_pct = 22;
		snk_idle_pct = 66;
		ctr_lat = 0; ctr_lon = 0; scl_x = 65536; scl_y = 65536; off_x = 0; off_y = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		drain();
		// Extremes of every register.
		write_all(843314857, -843314857, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8388607, -8388608);
		test_directed();
		drain();
		write_all(-843314857, 843314857, 0, 0, -8388608, 8388607);
		test_directed();
		drain();
		write_all(0, 0, 64'd1000 << 16, 64'd1000 << 16, 0, 0);
		test_random(200);
		drain();
		test_config_phase(300);
		src_idle_pct = 66;
		snk_idle_pct = 22;
		test_config_phase(300);
		test_config_phase(300);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_config_phase(300);
		test_config_phase(300);
		write_reg(3'd6, 32'hFFFF_FFFF);
		write_reg(3'd7, 32'h0);
		test_random(100);
		drain();

		if (mismatches == 0 && pending_pts.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/msp_pkg.sv
sv/msp_cordic.sv
sv/msp_log2.sv
sv/mercator_screen_projection_core.sv
sim/tb_top.sv
